// ----- design/nsf_pkg.sv -----
// ---------------------------------------------------------------------------
// NMEA sentence framer package
// Command codes and framing characters shared by the framer design.
// ---------------------------------------------------------------------------
package nsf_pkg;

  // Command carried with each input transaction.
  typedef enum logic [1:0] {
    CMD_RX      = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  // Framing characters.
  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Packed widths of the stream payloads.
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 136;

endpackage

// ----- design/nsf_ram.sv -----
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered and held
// while no read is issued.
// ---------------------------------------------------------------------------
module nsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/nmea_sentence_framer_fifo.sv -----
// ---------------------------------------------------------------------------
// NMEA sentence framer with sentence FIFO
// Frames NMEA sentences from received UART bytes into a ring of slots held
// in one RAM, and serves byte reads and releases of the oldest sentence.
// ---------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)            | tuser (low bit up)
//  in_     | slave     | rx_byte, read_index           | cmd, rx_error
//  out_    | master    | read_byte, pending_count,     | -
//          |           | oldest_length, sentence_done, |
//          |           | sentence_dropped, byte_count, |
//          |           | sentence_count, drop_count,   |
//          |           | error_count                   |
//
// One transaction is accepted per cycle while in_tready is high; its result
// leaves through the result stage (sentence RAM read) and the output register.
// All control state updates in the acceptance cycle, so the next transaction
// may follow immediately. Reset is synchronous and clears all control state;
// the sentence RAM is not cleared. A stall at the output holds the result
// stage and the RAM read data, and in_tready drops only when both the result
// stage and the output register are full.
// ---------------------------------------------------------------------------
module nmea_sentence_framer_fifo #(
  parameter int unsigned SLOT_BYTES = 128,
  parameter int unsigned SLOT_COUNT = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // rx_byte[7:0], read_index[14:8], zero fill [15]
  input  logic [nsf_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd[1:0], rx_error[2]
  input  logic [nsf_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_byte[7:0], pending_count[9:8], oldest_length[16:10],
  // sentence_done[17], sentence_dropped[18], byte_count[50:19],
  // sentence_count[82:51], drop_count[114:83], error_count[130:115],
  // zero fill [135:131]
  output logic [nsf_pkg::OUT_DATA_W-1:0]    out_tdata
);

  import nsf_pkg::*;

  localparam int unsigned FILL_W = $clog2(SLOT_BYTES);
  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam int unsigned PEND_W = $clog2(SLOT_COUNT);
  localparam int unsigned EXT_W  = FILL_W + 7;
  localparam int unsigned ADDR_W = SLOT_W + FILL_W;
  localparam int unsigned DEPTH  = SLOT_COUNT * (2 ** FILL_W);

  // Input field unpacking.
  logic [7:0] rx_byte;
  logic [6:0] read_index;
  logic       rx_error;
  cmd_t       cmd;
  logic       accept;

  assign rx_byte    = in_tdata[7:0];
  assign read_index = in_tdata[14:8];
  assign cmd        = cmd_t'(in_tuser[1:0]);
  assign rx_error   = in_tuser[2];

  // Control state.
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              cr_r, cr_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [FILL_W-1:0] len_r [SLOT_COUNT];
  logic [FILL_W-1:0] len_nxt [SLOT_COUNT];
  logic [31:0]       bytes_r, bytes_nxt;
  logic [31:0]       sents_r, sents_nxt;
  logic [31:0]       drops_r, drops_nxt;
  logic [15:0]       errs_r, errs_nxt;

  // Per-transaction decisions.
  logic              done, dropped, rd_ok;
  logic              ram_we, ram_re;
  logic [FILL_W-1:0] wpos;
  logic [FILL_W-1:0] fill_inc;
  logic [EXT_W-1:0]  idx_ext;
  logic [EXT_W-1:0]  tail_len_ext;
  logic [EXT_W-1:0]  olen_ext;
  logic [PEND_W+1:0] pend_ext;
  logic [SLOT_W-1:0] head_inc, tail_inc;

  assign fill_inc     = fill_r + 1'b1;
  assign head_inc     = (head_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc     = (tail_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : tail_r + 1'b1;
  assign idx_ext      = EXT_W'(read_index);
  assign tail_len_ext = EXT_W'(len_r[tail_r]);

  // Next-state logic for framing, ring pointers and counters.
  always_comb begin
    fill_nxt  = fill_r;
    cr_nxt    = cr_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    pend_nxt  = pend_r;
    bytes_nxt = bytes_r;
    sents_nxt = sents_r;
    drops_nxt = drops_r;
    errs_nxt  = errs_r;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      len_nxt[i] = len_r[i];
    end
    done    = 1'b0;
    dropped = 1'b0;
    rd_ok   = 1'b0;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    wpos    = fill_r;

    if (accept) begin
      unique case (cmd)
        CMD_RX: begin
          if (rx_error) begin
            errs_nxt = errs_r + 1'b1;
          end else begin
            bytes_nxt = bytes_r + 1'b1;
            if (rx_byte == CH_START) begin
              // Start character restarts assembly at slot position zero.
              ram_we   = 1'b1;
              wpos     = '0;
              fill_nxt = FILL_W'(1);
              cr_nxt   = 1'b0;
            end else if (fill_r != '0 && fill_r < FILL_W'(SLOT_BYTES - 1)) begin
              ram_we   = 1'b1;
              fill_nxt = fill_inc;
              cr_nxt   = (rx_byte == CH_CR);
              if (rx_byte == CH_LF && cr_r && fill_inc > FILL_W'(2)) begin
                // Sentence complete: queue it in place, or drop on full ring.
                if (pend_r == PEND_W'(SLOT_COUNT - 1)) begin
                  drops_nxt = drops_r + 1'b1;
                  dropped   = 1'b1;
                end else begin
                  len_nxt[head_r] = fill_inc;
                  head_nxt        = head_inc;
                  pend_nxt        = pend_r + 1'b1;
                  sents_nxt       = sents_r + 1'b1;
                  done            = 1'b1;
                end
                fill_nxt = '0;
                cr_nxt   = 1'b0;
              end
            end else if (fill_r != '0) begin
              // Overlong sentence is abandoned.
              fill_nxt = '0;
              cr_nxt   = 1'b0;
            end
          end
        end
        CMD_READ: begin
          ram_re = 1'b1;
          rd_ok  = (pend_r != '0) && (idx_ext < tail_len_ext);
        end
        CMD_RELEASE: begin
          if (pend_r != '0) begin
            tail_nxt = tail_inc;
            pend_nxt = pend_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status after the step; the length array is read with this step's write.
  assign olen_ext = (pend_nxt != '0) ? EXT_W'(len_nxt[tail_nxt]) : '0;
  assign pend_ext = (PEND_W + 2)'(pend_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      cr_r    <= 1'b0;
      head_r  <= '0;
      tail_r  <= '0;
      pend_r  <= '0;
      bytes_r <= '0;
      sents_r <= '0;
      drops_r <= '0;
      errs_r  <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      fill_r  <= fill_nxt;
      cr_r    <= cr_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      pend_r  <= pend_nxt;
      bytes_r <= bytes_nxt;
      sents_r <= sents_nxt;
      drops_r <= drops_nxt;
      errs_r  <= errs_nxt;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        len_r[i] <= len_nxt[i];
      end
    end
  end

  // Sentence store: writes go to the head slot, reads to the tail slot.
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        ram_rdata;

  assign waddr = {head_r, wpos};
  assign raddr = {tail_r, idx_ext[FILL_W-1:0]};

  nsf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (rx_byte),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Result stage waiting on the RAM read, then the output register.
  logic        s1_valid_r;
  logic        s1_rd_ok_r;
  logic [1:0]  s1_pend_r;
  logic [6:0]  s1_olen_r;
  logic        s1_done_r, s1_drop_r;
  logic [31:0] s1_bytes_r, s1_sents_r, s1_drops_r;
  logic [15:0] s1_errs_r;
  logic        s1_move;
  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [7:0]  s1_rd_byte;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign s1_rd_byte = s1_rd_ok_r ? ram_rdata : 8'h00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload snapshot of each transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd_ok_r <= rd_ok;
      s1_pend_r  <= pend_ext[1:0];
      s1_olen_r  <= olen_ext[6:0];
      s1_done_r  <= done;
      s1_drop_r  <= dropped;
      s1_bytes_r <= bytes_nxt;
      s1_sents_r <= sents_nxt;
      s1_drops_r <= drops_nxt;
      s1_errs_r  <= errs_nxt;
    end
    if (s1_move) begin
      out_data_r <= {5'b0, s1_errs_r, s1_drops_r, s1_sents_r, s1_bytes_r,
                     s1_drop_r, s1_done_r, s1_olen_r, s1_pend_r, s1_rd_byte};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
